FILE: rtl/cabe_pkg.sv
// Types and constants for the clipped alpha blit engine.
// Holds the item structs, command and result codes, and register indexes.
// No dependencies.
package cabe_pkg;

    typedef enum logic [1:0] {
        CMD_BLIT  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2
    } t_cmd;

    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_BLIT = 1'b1;

    localparam logic [2:0] REG_SOURCE_WIDTH  = 3'd0;
    localparam logic [2:0] REG_WINDOW_LEFT   = 3'd1;
    localparam logic [2:0] REG_WINDOW_TOP    = 3'd2;
    localparam logic [2:0] REG_WINDOW_WIDTH  = 3'd3;
    localparam logic [2:0] REG_WINDOW_HEIGHT = 3'd4;
    localparam logic [2:0] REG_DEST_X        = 3'd5;
    localparam logic [2:0] REG_DEST_Y        = 3'd6;
    localparam logic [2:0] REG_APPLY_ALPHA   = 3'd7;

    localparam int CFG_W   = 11;
    localparam int POS_W   = 11;
    localparam int SRC_W   = 10;
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [SRC_W-1:0] ROW_LIMIT = 10'd1023;
    localparam logic [CFG_W-1:0] SRC_WIDTH_MAX = 11'd1024;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } t_pixel;

    localparam t_pixel OPAQUE_BLACK = 32'h0000_00FF;

    typedef struct packed {
        logic [1:0] command;
        logic [8:0] coord_x;
        logic [7:0] coord_y;
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
        logic [7:0] in_alpha;
        logic       last_of_image;
    } t_in_item;

    typedef struct packed {
        logic       result_kind;
        logic [8:0] pixel_x;
        logic [7:0] pixel_y;
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
    } t_out_item;

endpackage

FILE: rtl/clipped_alpha_blit_engine_unit.sv
// Clipped alpha blit engine: RGBA frame store with blit, write and read items.
// Throughput 1 item per cycle while o_in_ready is high, set by the one-read
// one-write frame memory with a single forwarding register.
// Reset: synchronous active low; then a clearing pass over FRAME_WIDTH*FRAME_HEIGHT
// pixels writes opaque black with o_in_ready low; config writes are taken throughout.
// Depends on cabe_pkg.
module clipped_alpha_blit_engine_unit
    import cabe_pkg::*;
#(
    parameter int FRAME_WIDTH  = 512,
    parameter int FRAME_HEIGHT = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out,
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_index,
    input  logic [CFG_W-1:0]      i_cfg_data
);

    localparam int DEPTH = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = $clog2(FRAME_WIDTH);
    localparam int YW    = $clog2(FRAME_HEIGHT);

    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = 17'(x) + 17'(x[15:8]) + 17'd1;
        return t[15:8];
    endfunction

    function automatic logic [7:0] mix(input logic [7:0] s, input logic [7:0] d,
                                       input logic [7:0] a);
        logic [15:0] p;
        p = 16'(s) * 16'(a) + 16'(d) * 16'(8'd255 - a);
        return div255(p);
    endfunction

    // configuration
    logic [CFG_W-1:0] r_src_width;
    logic [SRC_W-1:0] r_win_left;
    logic [SRC_W-1:0] r_win_top;
    logic [CFG_W-1:0] r_win_width;
    logic [CFG_W-1:0] r_win_height;
    logic [8:0]       r_dest_x;
    logic [7:0]       r_dest_y;
    logic             r_apply_alpha;

    // source position
    logic [SRC_W-1:0] r_col, n_col;
    logic [SRC_W-1:0] r_row, n_row;

    // clearing pass
    logic             r_clr_active;
    logic [AW-1:0]    r_clr_addr;

    // stage A
    logic             r_sa_v;
    logic [1:0]       r_sa_cmd;
    logic             r_sa_hit;
    logic [POS_W-1:0] r_sa_x;
    logic [POS_W-1:0] r_sa_y;
    t_pixel           r_sa_px;

    // stage 1
    logic             r_s1_v;
    logic [1:0]       r_s1_cmd;
    logic             r_s1_hit;
    logic [POS_W-1:0] r_s1_x;
    logic [POS_W-1:0] r_s1_y;
    t_pixel           r_s1_px;
    logic [AW-1:0]    r_s1_addr;

    // frame memory and forwarding
    t_pixel           r_frame_mem [DEPTH];
    t_pixel           r_rdata;
    logic             r_fwd_v;
    logic [AW-1:0]    r_fwd_addr;
    t_pixel           r_fwd_data;

    // result queue
    t_out_item            r_q [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr_ptr;
    logic [Q_PTR_W-1:0]   r_rd_ptr;
    logic [Q_CNT_W-1:0]   r_q_cnt;

    logic             in_acc;
    logic [CFG_W-1:0] sw_eff;
    logic             whole;
    logic [SRC_W-1:0] left;
    logic [SRC_W-1:0] top;
    logic [CFG_W-1:0] ww;
    logic [SRC_W-1:0] col_off;
    logic [SRC_W-1:0] row_off;
    logic             col_ok;
    logic             row_ok;
    logic             a_hit;
    logic [POS_W-1:0] a_x;
    logic [POS_W-1:0] a_y;

    logic             sa_inside;
    logic [AW-1:0]    sa_addr;

    t_pixel           d_px;
    t_pixel           blend_px;
    t_pixel           blit_px;
    logic             item_we;
    t_pixel           item_wdata;
    logic             push;
    logic             pop;
    t_out_item        res;

    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    t_pixel           mem_wdata;

    assign o_in_ready = !r_clr_active &&
        ((r_q_cnt + Q_CNT_W'(r_sa_v) + Q_CNT_W'(r_s1_v)) <= Q_CNT_W'(Q_DEPTH - 1));
    assign in_acc = i_in_valid && o_in_ready;

    // geometry of the next source pixel
    always_comb begin
        if (r_src_width == '0) begin
            sw_eff = CFG_W'(1);
        end else if (r_src_width > SRC_WIDTH_MAX) begin
            sw_eff = SRC_WIDTH_MAX;
        end else begin
            sw_eff = r_src_width;
        end
        whole = (r_win_width == '0) || (r_win_height == '0);
        left  = whole ? '0 : r_win_left;
        top   = whole ? '0 : r_win_top;
        if (whole) begin
            ww = sw_eff;
        end else if (r_win_width > sw_eff) begin
            ww = sw_eff;
        end else begin
            ww = r_win_width;
        end
        col_off = r_col - left;
        row_off = r_row - top;
        col_ok  = (r_col >= left) && (CFG_W'(col_off) < ww);
        row_ok  = (r_row >= top) && (whole || (CFG_W'(row_off) < r_win_height));

        a_hit = 1'b0;
        a_x   = POS_W'(i_in.coord_x);
        a_y   = POS_W'(i_in.coord_y);
        case (i_in.command) inside
            CMD_BLIT: begin
                a_hit = col_ok && row_ok;
                a_x   = POS_W'(r_dest_x) + POS_W'(col_off);
                a_y   = POS_W'(r_dest_y) + POS_W'(row_off);
            end
            CMD_WRITE, CMD_READ: a_hit = 1'b1;
            default: a_hit = 1'b0;
        endcase

        n_col = r_col;
        n_row = r_row;
        if (in_acc && (i_in.command == CMD_BLIT)) begin
            if (i_in.last_of_image) begin
                n_col = '0;
                n_row = '0;
            end else if ((CFG_W'(r_col) + CFG_W'(1)) >= sw_eff) begin
                n_col = '0;
                n_row = (r_row == ROW_LIMIT) ? r_row : r_row + SRC_W'(1);
            end else begin
                n_col = r_col + SRC_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width   <= CFG_W'(512);
            r_win_left    <= '0;
            r_win_top     <= '0;
            r_win_width   <= '0;
            r_win_height  <= '0;
            r_dest_x      <= '0;
            r_dest_y      <= '0;
            r_apply_alpha <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_SOURCE_WIDTH:  r_src_width   <= i_cfg_data;
                REG_WINDOW_LEFT:   r_win_left    <= i_cfg_data[SRC_W-1:0];
                REG_WINDOW_TOP:    r_win_top     <= i_cfg_data[SRC_W-1:0];
                REG_WINDOW_WIDTH:  r_win_width   <= i_cfg_data;
                REG_WINDOW_HEIGHT: r_win_height  <= i_cfg_data;
                REG_DEST_X:        r_dest_x      <= i_cfg_data[8:0];
                REG_DEST_Y:        r_dest_y      <= i_cfg_data[7:0];
                REG_APPLY_ALPHA:   r_apply_alpha <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // stage A: hold position, read frame memory
    assign sa_inside = (r_sa_x < POS_W'(FRAME_WIDTH)) && (r_sa_y < POS_W'(FRAME_HEIGHT));
    assign sa_addr   = AW'(r_sa_y[YW-1:0]) * AW'(FRAME_WIDTH) + AW'(r_sa_x[XW-1:0]);

    // stage 1: forward, blend, write back, queue results
    always_comb begin
        d_px = (r_fwd_v && (r_fwd_addr == r_s1_addr)) ? r_fwd_data : r_rdata;
        blend_px.red   = mix(r_s1_px.red,   d_px.red,   r_s1_px.alpha);
        blend_px.green = mix(r_s1_px.green, d_px.green, r_s1_px.alpha);
        blend_px.blue  = mix(r_s1_px.blue,  d_px.blue,  r_s1_px.alpha);
        blend_px.alpha = r_s1_px.alpha +
                         div255(16'(d_px.alpha) * 16'(8'd255 - r_s1_px.alpha));
        blit_px = r_apply_alpha ? blend_px : r_s1_px;

        item_we    = 1'b0;
        item_wdata = blit_px;
        push       = 1'b0;
        res.result_kind = KIND_BLIT;
        res.pixel_x     = r_s1_x[8:0];
        res.pixel_y     = r_s1_y[7:0];
        {res.out_red, res.out_green, res.out_blue, res.out_alpha} = blit_px;
        case (r_s1_cmd)
            CMD_BLIT: begin
                item_we = r_s1_v && r_s1_hit;
                push    = r_s1_v && r_s1_hit;
            end
            CMD_WRITE: begin
                item_we    = r_s1_v && r_s1_hit;
                item_wdata = r_s1_px;
            end
            CMD_READ: begin
                push = r_s1_v;
                res.result_kind = KIND_READ;
                {res.out_red, res.out_green, res.out_blue, res.out_alpha} =
                    r_s1_hit ? d_px : '0;
            end
            default: ;
        endcase

        mem_we    = r_clr_active || item_we;
        mem_waddr = r_clr_active ? r_clr_addr : r_s1_addr;
        mem_wdata = r_clr_active ? OPAQUE_BLACK : item_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_frame_mem[mem_waddr] <= mem_wdata;
        end
        if (r_sa_v) begin
            r_rdata <= r_frame_mem[sa_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col        <= '0;
            r_row        <= '0;
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
            r_sa_v       <= 1'b0;
            r_s1_v       <= 1'b0;
            r_fwd_v      <= 1'b0;
        end else begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_sa_v  <= in_acc;
            r_s1_v  <= r_sa_v;
            r_fwd_v <= item_we;
            if (r_clr_active) begin
                r_clr_addr <= r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    r_clr_active <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_sa_cmd <= i_in.command;
            r_sa_hit <= a_hit;
            r_sa_x   <= a_x;
            r_sa_y   <= a_y;
            r_sa_px  <= {i_in.in_red, i_in.in_green, i_in.in_blue, i_in.in_alpha};
        end
        if (r_sa_v) begin
            r_s1_cmd  <= r_sa_cmd;
            r_s1_hit  <= r_sa_hit && sa_inside;
            r_s1_x    <= r_sa_x;
            r_s1_y    <= r_sa_y;
            r_s1_px   <= r_sa_px;
            r_s1_addr <= sa_addr;
        end
        if (item_we) begin
            r_fwd_addr <= r_s1_addr;
            r_fwd_data <= item_wdata;
        end
    end

    // result queue
    assign o_out_valid = (r_q_cnt != '0);
    assign o_out       = r_q[r_rd_ptr];
    assign pop         = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_q_cnt  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
            r_q_cnt <= r_q_cnt + Q_CNT_W'(push) - Q_CNT_W'(pop);
        end
    end

    a_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_q_cnt + Q_CNT_W'(r_sa_v) + Q_CNT_W'(r_s1_v)) <= Q_CNT_W'(Q_DEPTH))
        else $error("result queue credit exceeded");

    a_clr_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_active |-> (!r_sa_v && !r_s1_v && !item_we))
        else $error("item in flight during clearing pass");

    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !push) |=> (r_q_cnt == $past(r_q_cnt) - Q_CNT_W'(1)))
        else $error("result queue count slip");

endmodule
